>>> rtl/svcmd_pkg.sv
// Package: item types, parser phase codes and character constants for the velocity command driver.
`default_nettype none

package svcmd_pkg;

    // Field widths fixed by the item format
    localparam int MAG_W  = 10;
    localparam int DUTY_W = 8;
    localparam int ACC_W  = 14;

    // Saturation limits
    localparam logic [MAG_W-1:0]  MAG_SAT   = 10'd1023;
    localparam logic [DUTY_W-1:0] SPEED_MAX = 8'd255;

    // Characters the parser recognises
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_V     = 8'd86;

    // Line parser phase, one-hot
    typedef enum logic [8:0] {
        PH_START    = 9'b0_0000_0001,
        PH_BEFORE_A = 9'b0_0000_0010,
        PH_SIGN_A   = 9'b0_0000_0100,
        PH_DIG_A    = 9'b0_0000_1000,
        PH_BEFORE_B = 9'b0_0001_0000,
        PH_SIGN_B   = 9'b0_0010_0000,
        PH_DIG_B    = 9'b0_0100_0000,
        PH_DONE     = 9'b0_1000_0000,
        PH_FAIL     = 9'b1_0000_0000
    } ph_t;

    // Per-source line state
    typedef struct packed {
        ph_t              phase;
        logic [MAG_W-1:0] l_mag;
        logic             l_neg;
        logic [MAG_W-1:0] r_mag;
        logic             r_neg;
    } line_t;

    localparam line_t LINE_CLEAR = '{
        phase: PH_START,
        l_mag: '0,
        l_neg: 1'b0,
        r_mag: '0,
        r_neg: 1'b0
    };

    // End-of-line event from the parser to the drive stage
    typedef struct packed {
        logic             emit;
        logic             ok;
        logic [MAG_W-1:0] l_mag;
        logic             l_neg;
        logic [MAG_W-1:0] r_mag;
        logic             r_neg;
    } line_evt_t;

    // Input item
    typedef struct packed {
        logic       source;
        logic [7:0] byte_value;
    } cmd_item_t;

    // Result item
    typedef struct packed {
        logic              status;
        logic              left_forward;
        logic              left_reverse;
        logic [DUTY_W-1:0] left_duty;
        logic              right_forward;
        logic              right_reverse;
        logic [DUTY_W-1:0] right_duty;
    } rsp_item_t;

endpackage

`default_nettype wire

>>> rtl/svcmd_parse.sv
// Combinational one-character step of a line parser.
`default_nettype none

module svcmd_parse #(
    parameter int LINE_LIMIT = 31,
    parameter int CNT_W      = 5
) (
    input  var svcmd_pkg::line_t     line_cur,
    input  var logic [CNT_W-1:0]     cnt_cur,
    input  var logic [7:0]           byte_value,
    output svcmd_pkg::line_t         line_nxt,
    output logic [CNT_W-1:0]         cnt_nxt,
    output svcmd_pkg::line_evt_t     evt
);

    logic                       is_ws;
    logic                       is_sign;
    logic                       is_minus;
    logic                       is_dig;
    logic [3:0]                 digit;
    logic [svcmd_pkg::MAG_W-1:0] acc_l;
    logic [svcmd_pkg::MAG_W-1:0] acc_r;
    logic [svcmd_pkg::MAG_W-1:0] acc_0;

    // mag*10 + digit, saturating
    function automatic logic [svcmd_pkg::MAG_W-1:0] accum(
        input logic [svcmd_pkg::MAG_W-1:0] mag,
        input logic [3:0]                  d
    );
        logic [svcmd_pkg::ACC_W-1:0] v;
        v = {4'b0, mag} * 14'd10 + {10'b0, d};
        if (v > {4'b0, svcmd_pkg::MAG_SAT})
            return svcmd_pkg::MAG_SAT;
        else
            return v[svcmd_pkg::MAG_W-1:0];
    endfunction

    // Character classes
    assign is_ws    = (byte_value == svcmd_pkg::CH_SP) || (byte_value == svcmd_pkg::CH_TAB) ||
                      (byte_value == svcmd_pkg::CH_VT) || (byte_value == svcmd_pkg::CH_FF);
    assign is_minus = (byte_value == svcmd_pkg::CH_MINUS);
    assign is_sign  = (byte_value == svcmd_pkg::CH_PLUS) || is_minus;
    assign is_dig   = (byte_value >= svcmd_pkg::CH_ZERO) && (byte_value <= svcmd_pkg::CH_NINE);
    assign digit    = byte_value[3:0];

    assign acc_l = accum(line_cur.l_mag, digit);
    assign acc_r = accum(line_cur.r_mag, digit);
    assign acc_0 = accum('0, digit);

    // Next line state and end-of-line event
    always_comb
    begin
        line_nxt  = line_cur;
        cnt_nxt   = cnt_cur;
        evt.emit  = 1'b0;
        evt.ok    = (line_cur.phase == svcmd_pkg::PH_DIG_B) ||
                    (line_cur.phase == svcmd_pkg::PH_DONE);
        evt.l_mag = line_cur.l_mag;
        evt.l_neg = line_cur.l_neg;
        evt.r_mag = line_cur.r_mag;
        evt.r_neg = line_cur.r_neg;

        priority if (byte_value == svcmd_pkg::CH_CR)
        begin
            // carriage return dropped
            cnt_nxt = cnt_cur;
        end
        else if (byte_value == svcmd_pkg::CH_LF)
        begin
            evt.emit = (cnt_cur != '0);
            line_nxt = svcmd_pkg::LINE_CLEAR;
            cnt_nxt  = '0;
        end
        else if (cnt_cur < CNT_W'(LINE_LIMIT))
        begin
            cnt_nxt = cnt_cur + 1'b1;
            if (byte_value == svcmd_pkg::CH_NUL)
            begin
                // NUL ends the parsed text
                line_nxt.phase = evt.ok ? svcmd_pkg::PH_DONE : svcmd_pkg::PH_FAIL;
            end
            else
            begin
                unique case (line_cur.phase)
                    svcmd_pkg::PH_START:
                        line_nxt.phase = (byte_value == svcmd_pkg::CH_V) ?
                                         svcmd_pkg::PH_BEFORE_A : svcmd_pkg::PH_FAIL;
                    svcmd_pkg::PH_BEFORE_A:
                        priority if (is_ws)
                            line_nxt.phase = svcmd_pkg::PH_BEFORE_A;
                        else if (is_sign)
                        begin
                            line_nxt.l_neg = is_minus;
                            line_nxt.phase = svcmd_pkg::PH_SIGN_A;
                        end
                        else if (is_dig)
                        begin
                            line_nxt.l_mag = acc_0;
                            line_nxt.phase = svcmd_pkg::PH_DIG_A;
                        end
                        else
                            line_nxt.phase = svcmd_pkg::PH_FAIL;
                    svcmd_pkg::PH_SIGN_A:
                        if (is_dig)
                        begin
                            line_nxt.l_mag = acc_l;
                            line_nxt.phase = svcmd_pkg::PH_DIG_A;
                        end
                        else
                            line_nxt.phase = svcmd_pkg::PH_FAIL;
                    svcmd_pkg::PH_DIG_A:
                        priority if (is_dig)
                        begin
                            line_nxt.l_mag = acc_l;
                            line_nxt.phase = svcmd_pkg::PH_DIG_A;
                        end
                        else if (is_ws)
                            line_nxt.phase = svcmd_pkg::PH_BEFORE_B;
                        else if (is_sign)
                        begin
                            line_nxt.r_neg = is_minus;
                            line_nxt.phase = svcmd_pkg::PH_SIGN_B;
                        end
                        else
                            line_nxt.phase = svcmd_pkg::PH_FAIL;
                    svcmd_pkg::PH_BEFORE_B:
                        priority if (is_ws)
                            line_nxt.phase = svcmd_pkg::PH_BEFORE_B;
                        else if (is_sign)
                        begin
                            line_nxt.r_neg = is_minus;
                            line_nxt.phase = svcmd_pkg::PH_SIGN_B;
                        end
                        else if (is_dig)
                        begin
                            line_nxt.r_mag = acc_0;
                            line_nxt.phase = svcmd_pkg::PH_DIG_B;
                        end
                        else
                            line_nxt.phase = svcmd_pkg::PH_FAIL;
                    svcmd_pkg::PH_SIGN_B:
                        if (is_dig)
                        begin
                            line_nxt.r_mag = acc_r;
                            line_nxt.phase = svcmd_pkg::PH_DIG_B;
                        end
                        else
                            line_nxt.phase = svcmd_pkg::PH_FAIL;
                    svcmd_pkg::PH_DIG_B:
                        if (is_dig)
                        begin
                            line_nxt.r_mag = acc_r;
                            line_nxt.phase = svcmd_pkg::PH_DIG_B;
                        end
                        else
                            line_nxt.phase = svcmd_pkg::PH_DONE;
                    svcmd_pkg::PH_DONE:
                        line_nxt.phase = svcmd_pkg::PH_DONE;
                    default:
                        line_nxt.phase = svcmd_pkg::PH_FAIL;
                endcase
            end
        end
        else
        begin
            // past the line limit: character dropped
            cnt_nxt = cnt_cur;
        end
    end

endmodule

`default_nettype wire

>>> rtl/svcmd_drive.sv
// Drive register and result output register with its handshake.
`default_nettype none

module svcmd_drive (
    input  var logic                 clk,
    input  var logic                 rst_n,
    input  var svcmd_pkg::line_evt_t evt,
    output logic                     can_take,
    output logic                     rsp_valid,
    input  var logic                 rsp_stall,
    output svcmd_pkg::rsp_item_t     rsp_item
);

    // forward, reverse, duty for one wheel
    typedef struct packed {
        logic                         fwd;
        logic                         rev;
        logic [svcmd_pkg::DUTY_W-1:0] duty;
    } wheel_t;

    wheel_t               left_reg;
    wheel_t               left_next;
    wheel_t               right_reg;
    wheel_t               right_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    svcmd_pkg::rsp_item_t rsp_item_reg;
    svcmd_pkg::rsp_item_t rsp_item_next;

    function automatic wheel_t wheel(
        input logic [svcmd_pkg::MAG_W-1:0] mag,
        input logic                        neg
    );
        wheel_t w;
        if (mag == '0)
            w = '0;
        else
        begin
            w.fwd  = ~neg;
            w.rev  = neg;
            w.duty = (mag > svcmd_pkg::MAG_W'(svcmd_pkg::SPEED_MAX)) ?
                     svcmd_pkg::SPEED_MAX : mag[svcmd_pkg::DUTY_W-1:0];
        end
        return w;
    endfunction

    assign can_take = ~rsp_valid_reg | ~rsp_stall;

    // Drive update on an accepted line
    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        if (evt.emit && evt.ok)
        begin
            left_next  = wheel(evt.l_mag, evt.l_neg);
            right_next = wheel(evt.r_mag, evt.r_neg);
        end
    end

    // Result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        rsp_item_next  = rsp_item_reg;
        if (evt.emit)
        begin
            rsp_valid_next              = 1'b1;
            rsp_item_next.status        = ~evt.ok;
            rsp_item_next.left_forward  = left_next.fwd;
            rsp_item_next.left_reverse  = left_next.rev;
            rsp_item_next.left_duty     = left_next.duty;
            rsp_item_next.right_forward = right_next.fwd;
            rsp_item_next.right_reverse = right_next.rev;
            rsp_item_next.right_duty    = right_next.duty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

`default_nettype wire

>>> rtl/serial_velocity_command_motor_driver.sv
// A newline is taken into the input register, parsed, and its result is registered in the result register.
// Throughput: one item per cycle but for the hold below; each byte passes the input register and one parser step.
// Only a newline that closes a line with a waiting, stalled result holds the input side.
// Reset: asynchronous, active low; every line parser returns to line start with empty
// counts and the drive stops (all direction bits and duties zero). No clearing pass.
`default_nettype none

module serial_velocity_command_motor_driver #(
    parameter int LINE_LIMIT  = 31,
    parameter int NUM_SOURCES = 2
) (
    input  var logic                   clk,
    input  var logic                   rst_n,
    input  var logic                   cmd_valid,
    output logic                       cmd_stall,
    input  var svcmd_pkg::cmd_item_t   cmd_item,
    output logic                       rsp_valid,
    input  var logic                   rsp_stall,
    output svcmd_pkg::rsp_item_t       rsp_item
);

    localparam int CNT_W = $clog2(LINE_LIMIT + 1);
    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    svcmd_pkg::cmd_item_t s1_item_reg;
    logic                 cmd_take;
    logic                 s1_go;
    logic                 src_ok;
    logic                 want_emit;
    logic                 can_take;
    logic [IDX_W-1:0]     idx;

    svcmd_pkg::line_t     line_reg [NUM_SOURCES];
    logic [CNT_W-1:0]     cnt_reg  [NUM_SOURCES];
    svcmd_pkg::line_t     line_cur;
    logic [CNT_W-1:0]     cnt_cur;
    svcmd_pkg::line_t     line_next;
    logic [CNT_W-1:0]     cnt_next;
    svcmd_pkg::line_evt_t evt;
    svcmd_pkg::line_evt_t commit;

    // Source select; bytes from an unknown source are dropped
    assign src_ok   = (int'(s1_item_reg.source) < NUM_SOURCES);
    assign idx      = src_ok ? IDX_W'(s1_item_reg.source) : '0;
    assign line_cur = line_reg[idx];
    assign cnt_cur  = cnt_reg[idx];

    svcmd_parse #(
        .LINE_LIMIT (LINE_LIMIT),
        .CNT_W      (CNT_W)
    ) u_parse (
        .line_cur   (line_cur),
        .cnt_cur    (cnt_cur),
        .byte_value (s1_item_reg.byte_value),
        .line_nxt   (line_next),
        .cnt_nxt    (cnt_next),
        .evt        (evt)
    );

    // Stage advance: held only when a result must wait for the output
    assign want_emit = s1_valid_reg & src_ok & evt.emit;
    assign s1_go     = s1_valid_reg & (~want_emit | can_take);
    assign cmd_stall = s1_valid_reg & ~s1_go;
    assign cmd_take  = cmd_valid & ~cmd_stall;

    always_comb
    begin
        commit      = evt;
        commit.emit = want_emit & can_take;
    end

    svcmd_drive u_drive (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (commit),
        .can_take  (can_take),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    // Input register
    always_comb
    begin
        s1_valid_next = s1_valid_reg & ~s1_go;
        if (cmd_take)
            s1_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            s1_item_reg <= cmd_item;
    end

    // Per-source line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                line_reg[i] <= svcmd_pkg::LINE_CLEAR;
                cnt_reg[i]  <= '0;
            end
        end
        else if (s1_go && src_ok)
        begin
            line_reg[idx] <= line_next;
            cnt_reg[idx]  <= cnt_next;
        end
    end

    // Input side stalls only while an item is held
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> s1_valid_reg)
    else $error("input stalled with empty stage");

    // A line end that cannot reach a stalled full output must hold the input
    assert property (@(posedge clk) disable iff (!rst_n)
        want_emit && rsp_valid && rsp_stall |-> cmd_stall)
    else $error("result would overwrite a waiting item");

    // A new result follows a parsed line end
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(commit.emit))
    else $error("result appeared without a line end");

endmodule

`default_nettype wire

>>> bench/drive_line_checker.sv
// Checker for the velocity command driver: predicts drive results from accepted bytes and compares them.
module drive_line_checker
    import svcmd_pkg::*;
#(
    parameter int LINE_LIMIT = 31
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  logic      cmd_stall,
    input  cmd_item_t cmd_item,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_item_t rsp_item,
    output int        fail_count,
    output int        pending
);

    // Per-link line state and the shared drive
    ph_t              phase  [2];
    int               kept   [2];
    logic [MAG_W-1:0] l_mag  [2];
    logic             l_neg  [2];
    logic [MAG_W-1:0] r_mag  [2];
    logic             r_neg  [2];
    rsp_item_t        drive;

    rsp_item_t expected_drive_q[$];
    int        errors = 0;
    int        depth  = 0;

    assign fail_count = errors;
    assign pending    = depth;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 40)
            $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Decimal accumulate, saturating
    function automatic logic [MAG_W-1:0] accumulate(logic [MAG_W-1:0] mag, logic [7:0] c);
        int v;
        v = int'(mag) * 10 + int'(c) - int'(CH_ZERO);
        if (v > int'(MAG_SAT))
            return MAG_SAT;
        return v[MAG_W-1:0];
    endfunction

    // {forward, reverse, duty} for one wheel
    function automatic logic [DUTY_W+1:0] wheel(logic [MAG_W-1:0] mag, logic neg);
        if (mag == '0)
            return '0;
        if (mag > MAG_W'(SPEED_MAX))
            return {~neg, neg, SPEED_MAX};
        return {~neg, neg, mag[DUTY_W-1:0]};
    endfunction

    function automatic void clear_line(logic s);
        phase[s] = PH_START;
        kept[s]  = 0;
        l_mag[s] = '0;
        l_neg[s] = 1'b0;
        r_mag[s] = '0;
        r_neg[s] = 1'b0;
    endfunction

    // One parser step on a kept character
    function automatic ph_t next_phase(logic s, logic [7:0] c);
        ph_t ph;
        bit  sgn;
        ph  = phase[s];
        sgn = (c == CH_PLUS) || (c == CH_MINUS);
        // a NUL ends the text the parser sees
        if (c == CH_NUL)
        begin
            if (ph == PH_DIG_B || ph == PH_DONE)
                return PH_DONE;
            return PH_FAIL;
        end
        case (ph)
            PH_START:
            begin
                if (c == CH_V)
                    return PH_BEFORE_A;
                return PH_FAIL;
            end
            PH_BEFORE_A:
            begin
                if (is_space(c))
                    return PH_BEFORE_A;
                if (sgn)
                begin
                    l_neg[s] = (c == CH_MINUS);
                    return PH_SIGN_A;
                end
                if (is_digit(c))
                begin
                    l_mag[s] = accumulate('0, c);
                    return PH_DIG_A;
                end
                return PH_FAIL;
            end
            PH_SIGN_A, PH_DIG_A:
            begin
                if (is_digit(c))
                begin
                    l_mag[s] = accumulate(l_mag[s], c);
                    return PH_DIG_A;
                end
                if (ph == PH_SIGN_A)
                    return PH_FAIL;
                if (is_space(c))
                    return PH_BEFORE_B;
                // second number may follow the first directly when it starts with a sign
                if (sgn)
                begin
                    r_neg[s] = (c == CH_MINUS);
                    return PH_SIGN_B;
                end
                return PH_FAIL;
            end
            PH_BEFORE_B:
            begin
                if (is_space(c))
                    return PH_BEFORE_B;
                if (sgn)
                begin
                    r_neg[s] = (c == CH_MINUS);
                    return PH_SIGN_B;
                end
                if (is_digit(c))
                begin
                    r_mag[s] = accumulate('0, c);
                    return PH_DIG_B;
                end
                return PH_FAIL;
            end
            PH_SIGN_B, PH_DIG_B:
            begin
                if (is_digit(c))
                begin
                    r_mag[s] = accumulate(r_mag[s], c);
                    return PH_DIG_B;
                end
                if (ph == PH_DIG_B)
                    return PH_DONE;
                return PH_FAIL;
            end
            PH_DONE:
                return PH_DONE;
            default:
                return PH_FAIL;
        endcase
    endfunction

    // Accepted byte: update the line and queue a result at a non-empty newline
    task automatic take_byte(logic s, logic [7:0] c);
        rsp_item_t r;
        if (c == CH_CR)
            return;
        if (c != CH_LF)
        begin
            if (kept[s] < LINE_LIMIT)
            begin
                kept[s]++;
                phase[s] = next_phase(s, c);
            end
            return;
        end
        if (kept[s] != 0)
        begin
            r = drive;
            if (phase[s] == PH_DIG_B || phase[s] == PH_DONE)
            begin
                r.status = 1'b0;
                {r.left_forward, r.left_reverse, r.left_duty}    = wheel(l_mag[s], l_neg[s]);
                {r.right_forward, r.right_reverse, r.right_duty} = wheel(r_mag[s], r_neg[s]);
                drive = r;
            end
            else
                r.status = 1'b1;
            expected_drive_q.push_back(r);
        end
        clear_line(s);
    endtask

    // Compare one result against the oldest expectation
    task automatic check_result(rsp_item_t got);
        rsp_item_t want;
        if (expected_drive_q.size() == 0)
        begin
            report_mismatch("unexpected result", int'(got), 0);
            return;
        end
        want = expected_drive_q.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.left_forward !== want.left_forward)
            report_mismatch("left_forward", got.left_forward, want.left_forward);
        if (got.left_reverse !== want.left_reverse)
            report_mismatch("left_reverse", got.left_reverse, want.left_reverse);
        if (got.left_duty !== want.left_duty)
            report_mismatch("left_duty", got.left_duty, want.left_duty);
        if (got.right_forward !== want.right_forward)
            report_mismatch("right_forward", got.right_forward, want.right_forward);
        if (got.right_reverse !== want.right_reverse)
            report_mismatch("right_reverse", got.right_reverse, want.right_reverse);
        if (got.right_duty !== want.right_duty)
            report_mismatch("right_duty", got.right_duty, want.right_duty);
    endtask

    // Watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_line(1'b0);
            clear_line(1'b1);
            drive = '0;
            expected_drive_q.delete();
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_result(rsp_item);
            if (cmd_valid && !cmd_stall)
                take_byte(cmd_item.source, cmd_item.byte_value);
        end
        depth = expected_drive_q.size();
    end

endmodule

>>> bench/tb_top.sv
// Top of the velocity command driver bench: clock, reset, byte stimulus, result stalls and verdict.
module tb_top;
    import svcmd_pkg::*;

    localparam int LINE_LIMIT   = 31;
    localparam int NUM_SOURCES  = 2;
    localparam int PHASE_ITEMS  = 480;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 300000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd_item  = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_item_t rsp_item;

    int fail_count;
    int pending;

    int send_idle = 0;
    int recv_idle = 0;
    bit hold_go   = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int cycles    = 0;

    logic [7:0] new_line[$];
    logic [7:0] radio_bytes[$];
    logic [7:0] usb_bytes[$];

    serial_velocity_command_motor_driver #(
        .LINE_LIMIT (LINE_LIMIT),
        .NUM_SOURCES(NUM_SOURCES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_item (cmd_item),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_item (rsp_item)
    );

    drive_line_checker #(
        .LINE_LIMIT(LINE_LIMIT)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver stalls, with one long hold-off counted here
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_go && !hold_done)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < recv_idle);
    end

    // One item: optional gaps, then hold until accepted; returns at a falling edge
    task automatic send_byte(logic s, logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= '{source: s, byte_value: b};
        do
            @(posedge clk);
        while (cmd_stall);
        @(negedge clk);
    endtask

    task automatic send_text(logic s, string t);
        for (int i = 0; i < t.len(); i++)
            send_byte(s, t[i]);
    endtask

    function automatic logic [7:0] any_space();
        case ($urandom_range(3))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    task automatic add_spaces(int n);
        repeat (n)
            new_line.push_back(any_space());
    endtask

    // Optional sign then digits; now and then no digits at all
    task automatic add_number(bit with_sign);
        int nd;
        if (with_sign)
            new_line.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
        if ($urandom_range(29) == 0)
            nd = 0;
        else if ($urandom_range(9) == 0)
            nd = $urandom_range(4, 8);
        else
            nd = $urandom_range(1, 3);
        repeat (nd)
            new_line.push_back(CH_ZERO + 8'($urandom_range(9)));
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == CH_LF)
            b = CH_V;
        return b;
    endfunction

    // Build one line, mostly well formed, the rest broken, noise or empty
    task automatic build_line();
        int  kind;
        bit  sgn;
        new_line.delete();
        kind = $urandom_range(99);
        if (kind < 90)
        begin
            new_line.push_back(CH_V);
            add_spaces($urandom_range(2));
            if ($urandom_range(19) == 0)
                add_spaces($urandom_range(10, 30));
            add_number($urandom_range(2) == 0);
            sgn = ($urandom_range(2) == 0);
            add_spaces(sgn ? $urandom_range(2) : $urandom_range(1, 2));
            add_number(sgn);
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 6))
                    new_line.push_back(8'($urandom_range(32, 126)));
            // one character corrupted
            if (kind >= 68 && kind < 80)
                new_line[$urandom_range(new_line.size() - 1)] = noise_byte();
            // NUL somewhere in the line
            if (kind >= 80)
                new_line.insert($urandom_range(new_line.size()), CH_NUL);
        end
        else if (kind < 96)
        begin
            repeat ($urandom_range(40))
                new_line.push_back(noise_byte());
        end
        if ($urandom_range(7) == 0)
            new_line.insert($urandom_range(new_line.size()), CH_CR);
        new_line.push_back(CH_LF);
    endtask

    // Random bytes from both links, lines interleaved between them
    task automatic run_random(int n_items);
        logic       s;
        logic [7:0] b;
        s = 1'b0;
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(4) == 0)
                s = ~s;
            if (s == 1'b0)
            begin
                if (radio_bytes.size() == 0)
                begin
                    build_line();
                    foreach (new_line[k])
                        radio_bytes.push_back(new_line[k]);
                end
                b = radio_bytes.pop_front();
            end
            else
            begin
                if (usb_bytes.size() == 0)
                begin
                    build_line();
                    foreach (new_line[k])
                        usb_bytes.push_back(new_line[k]);
                end
                b = usb_bytes.pop_front();
            end
            send_byte(s, b);
        end
    endtask

    // Directed lines: extremes, saturation, signs, whitespace, NUL, long and empty lines
    task automatic run_directed();
        send_text(0, "V255 -255\n");
        send_text(1, "V-1023 +99999\n");
        send_text(0, "V 0 -0\n");
        send_text(1, "V 5-3\n");
        send_text(0, "V\t+7");
        send_byte(0, CH_VT);
        send_byte(0, CH_FF);
        send_text(0, "-8 junk\r\n");
        send_text(1, "V - 5\n");
        send_text(0, "V 12\n");
        send_text(1, "X 1 2\n");
        send_text(0, "v 1 2\n");
        send_text(0, "\r\n");
        send_text(1, "\n");
        send_text(0, "V 1 2");
        send_byte(0, CH_NUL);
        send_text(0, "zz\n");
        send_text(1, "V 1");
        send_byte(1, CH_NUL);
        send_text(1, " 2\n");
        send_text(0, {"V", {30{" "}}, "9 9\n"});
        send_text(1, {"V 100 200", {40{"x"}}, "\n"});
        send_text(0, "V1 ");
        send_text(1, "V-2 3\n");
        send_text(0, "4\n");
        send_text(1, "V12");
        send_byte(1, CH_CR);
        send_text(1, " 34\n");
        send_byte(1, 8'hFF);
        send_text(1, "\n");
    endtask

    initial
    begin
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle = 34;
        recv_idle <= 71;
        run_directed();
        run_random(PHASE_ITEMS);

        send_idle = 71;
        recv_idle <= 34;
        run_random(PHASE_ITEMS);

        // no idling; long receiver hold-off at the start
        send_idle = 0;
        recv_idle <= 0;
        hold_go   <= 1'b1;
        run_random(PHASE_ITEMS);
        cmd_valid <= 1'b0;

        // drain
        while (pending != 0)
            @(negedge clk);
        repeat (8)
            @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
